### rtl/pulse_fiducial_detector_unit_assert.svh
// ----------------------------------------------------------------------------
// Pulse fiducial detector assertion macros
// Shared concurrent assertion forms for the detector modules.
// ----------------------------------------------------------------------------
`ifndef PULSE_FIDUCIAL_DETECTOR_UNIT_ASSERT_SVH
`define PULSE_FIDUCIAL_DETECTOR_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfd: same-cycle check failed");

// next-cycle implication, disabled during reset
`define PFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfd: next-cycle check failed");

`endif

### rtl/pfd_pkg.sv
// ----------------------------------------------------------------------------
// pfd_pkg
// Types, constants and codes shared by the pulse fiducial detector.
// ----------------------------------------------------------------------------
package pfd_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int INDEX_BITS    = 16;
  localparam int CFG_IDX_BITS  = 1;
  localparam int FIFO_DEPTH    = 2;
  localparam int FIFO_PTR_BITS = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  // Q1.15-style thresholds scaled to the sample width, rounded to nearest
  localparam longint Q_ONE           = longint'(1) << (SAMPLE_BITS - 1);
  localparam longint SYS_THR_RST_INT = (65 * Q_ONE + 50) / 100;
  localparam longint DIA_THR_RST_INT = (20 * Q_ONE + 50) / 100;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic        [INDEX_BITS-1:0]  index_t;

  localparam sample_t SYS_THR_RST = sample_t'(SYS_THR_RST_INT);
  localparam sample_t DIA_THR_RST = sample_t'(DIA_THR_RST_INT);

  typedef enum logic [1:0] {
    EV_SYSTOLIC  = 2'd0,
    EV_DIASTOLIC = 2'd1,
    EV_VALLEY    = 2'd2,
    EV_NOTCH     = 2'd3
  } event_kind_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SYS_THR = 1'b0,
    CFG_DIA_THR = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    sample_t sample;
    logic    end_of_record;
  } in_t;

  typedef struct packed {
    event_kind_e event_kind;
    index_t      position;
    sample_t     level;
    logic        last_of_run;
  } out_t;

  // all events caused by one sample, in emission order valley, notch, peak
  typedef struct packed {
    logic        valley_vld;
    logic        notch_vld;
    logic        peak_vld;
    event_kind_e peak_kind;
    index_t      valley_pos;
    sample_t     valley_lvl;
    index_t      notch_pos;
    sample_t     notch_lvl;
    index_t      peak_pos;
    sample_t     peak_lvl;
  } job_t;

endpackage

### rtl/pfd_front.sv
// ----------------------------------------------------------------------------
// pfd_front
// Accepts samples, runs the delay line and fiducial state, and pushes the
// events of each sample as one job into the event queue.
// ----------------------------------------------------------------------------
`include "pulse_fiducial_detector_unit_assert.svh"

module pfd_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pfd_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [pfd_pkg::SAMPLE_BITS-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  input  pfd_pkg::in_t                        in_data_i,
  output logic                                in_stall_o,
  input  logic                                q_full_i,
  output logic                                q_push_o,
  output pfd_pkg::job_t                       q_job_o
);
  import pfd_pkg::*;

  localparam logic [1:0] WARM_FULL = 2'd3;

  sample_t sys_thr_q, dia_thr_q;
  sample_t r0_q, r1_q, r2_q, r0_d, r1_d, r2_d;
  index_t  cnt_q, cnt_d;
  logic [1:0] warm_q, warm_d;
  logic    sys_seen_q, sys_seen_d;
  sample_t min_lvl_q, min_lvl_d;
  index_t  min_pos_q, min_pos_d;
  logic    dia_since_q, dia_since_d;
  logic    notch_pend_q, notch_pend_d;
  index_t  notch_pos_q, notch_pos_d;
  sample_t notch_lvl_q, notch_lvl_d;

  logic    accept, peak, is_sys, is_dia;
  sample_t cur;
  index_t  p;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign cur        = in_data_i.sample;
  assign p          = cnt_q - INDEX_BITS'(2);

  assign peak   = (warm_q == WARM_FULL) && (r1_q > r2_q) && (r0_q <= r1_q) && (r0_q > cur);
  assign is_sys = peak && (r1_q > sys_thr_q);
  assign is_dia = peak && !is_sys && (r1_q > dia_thr_q) && (r1_q < sys_thr_q);

  always_comb begin
    q_job_o            = '0;
    q_job_o.valley_vld = is_sys && sys_seen_q;
    q_job_o.notch_vld  = is_sys && notch_pend_q;
    q_job_o.peak_vld   = is_sys || is_dia;
    q_job_o.peak_kind  = is_sys ? EV_SYSTOLIC : EV_DIASTOLIC;
    q_job_o.valley_pos = min_pos_q;
    q_job_o.valley_lvl = min_lvl_q;
    q_job_o.notch_pos  = notch_pos_q;
    q_job_o.notch_lvl  = notch_lvl_q;
    q_job_o.peak_pos   = p;
    q_job_o.peak_lvl   = r1_q;
  end

  assign q_push_o = accept && (is_sys || is_dia);

  always_comb begin
    r0_d         = r0_q;
    r1_d         = r1_q;
    r2_d         = r2_q;
    cnt_d        = cnt_q;
    warm_d       = warm_q;
    sys_seen_d   = sys_seen_q;
    min_lvl_d    = min_lvl_q;
    min_pos_d    = min_pos_q;
    dia_since_d  = dia_since_q;
    notch_pend_d = notch_pend_q;
    notch_pos_d  = notch_pos_q;
    notch_lvl_d  = notch_lvl_q;
    if (accept) begin
      if (is_sys) begin
        sys_seen_d   = 1'b1;
        notch_pend_d = 1'b0;
        dia_since_d  = 1'b0;
        min_lvl_d    = r1_q;
        min_pos_d    = p;
      end else begin
        if (is_dia && sys_seen_q && !dia_since_q) begin
          notch_pend_d = 1'b1;
          notch_pos_d  = min_pos_q;
          notch_lvl_d  = min_lvl_q;
          dia_since_d  = 1'b1;
        end
        if (peak || (warm_q == WARM_FULL)) begin
          if (sys_seen_q && (r1_q < min_lvl_q)) begin
            min_lvl_d = r1_q;
            min_pos_d = p;
          end
        end
      end
      r2_d  = r1_q;
      r1_d  = r0_q;
      r0_d  = cur;
      cnt_d = cnt_q + INDEX_BITS'(1);
      if (warm_q != WARM_FULL) begin
        warm_d = warm_q + 2'd1;
      end
      if (in_data_i.end_of_record) begin
        r0_d         = '0;
        r1_d         = '0;
        r2_d         = '0;
        cnt_d        = '0;
        warm_d       = '0;
        sys_seen_d   = 1'b0;
        min_lvl_d    = '0;
        min_pos_d    = '0;
        dia_since_d  = 1'b0;
        notch_pend_d = 1'b0;
        notch_pos_d  = '0;
        notch_lvl_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sys_thr_q    <= SYS_THR_RST;
      dia_thr_q    <= DIA_THR_RST;
      r0_q         <= '0;
      r1_q         <= '0;
      r2_q         <= '0;
      cnt_q        <= '0;
      warm_q       <= '0;
      sys_seen_q   <= 1'b0;
      min_lvl_q    <= '0;
      min_pos_q    <= '0;
      dia_since_q  <= 1'b0;
      notch_pend_q <= 1'b0;
      notch_pos_q  <= '0;
      notch_lvl_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_SYS_THR: sys_thr_q <= cfg_data_i;
          CFG_DIA_THR: dia_thr_q <= cfg_data_i;
          default: ;
        endcase
      end
      r0_q         <= r0_d;
      r1_q         <= r1_d;
      r2_q         <= r2_d;
      cnt_q        <= cnt_d;
      warm_q       <= warm_d;
      sys_seen_q   <= sys_seen_d;
      min_lvl_q    <= min_lvl_d;
      min_pos_q    <= min_pos_d;
      dia_since_q  <= dia_since_d;
      notch_pend_q <= notch_pend_d;
      notch_pos_q  <= notch_pos_d;
      notch_lvl_q  <= notch_lvl_d;
    end
  end

  `PFD_ASSERT_NOW(a_notch_needs_sys, clk_i, rst_ni, notch_pend_q, sys_seen_q && dia_since_q)
  `PFD_ASSERT_NOW(a_push_only_warm, clk_i, rst_ni, q_push_o, warm_q == WARM_FULL)

endmodule

### rtl/pfd_fifo.sv
// ----------------------------------------------------------------------------
// pfd_fifo
// Short job queue between the sample front end and the event sequencer.
// ----------------------------------------------------------------------------
`include "pulse_fiducial_detector_unit_assert.svh"

module pfd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pfd_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output pfd_pkg::job_t pop_data_o
);
  import pfd_pkg::*;

  localparam logic [FIFO_PTR_BITS-1:0] PTR_LAST = FIFO_PTR_BITS'(FIFO_DEPTH - 1);
  localparam logic [FIFO_CNT_BITS-1:0] CNT_FULL = FIFO_CNT_BITS'(FIFO_DEPTH);

  job_t mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_BITS-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o     = (cnt_q == CNT_FULL);
  assign valid_o    = (cnt_q != '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + FIFO_PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + FIFO_PTR_BITS'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + FIFO_CNT_BITS'(1);
        2'b01:   cnt_q <= cnt_q - FIFO_CNT_BITS'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  `PFD_ASSERT_NOW(a_no_push_when_full, clk_i, rst_ni, push_i, !full_o)

endmodule

### rtl/pfd_back.sv
// ----------------------------------------------------------------------------
// pfd_back
// Takes jobs from the queue and sends their events one per cycle, unless the
// output stalls, via a registered output stage: valley, notch, then the peak.
// ----------------------------------------------------------------------------
`include "pulse_fiducial_detector_unit_assert.svh"

module pfd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  pfd_pkg::job_t q_job_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output pfd_pkg::out_t out_data_o
);
  import pfd_pkg::*;

  localparam int BIT_VALLEY = 0;
  localparam int BIT_NOTCH  = 1;
  localparam int BIT_PEAK   = 2;

  job_t       job_q, job_d;
  logic [2:0] mask_q, mask_d, rem;
  logic       out_vld_q, out_vld_d;
  out_t       out_q, out_d;
  logic       adv;

  assign adv = !out_vld_q || !out_stall_i;

  always_comb begin
    job_d     = job_q;
    mask_d    = mask_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && out_stall_i;
    rem       = mask_q;
    if (adv && (mask_q != '0)) begin
      if (mask_q[BIT_VALLEY]) begin
        out_d.event_kind = EV_VALLEY;
        out_d.position   = job_q.valley_pos;
        out_d.level      = job_q.valley_lvl;
        rem[BIT_VALLEY]  = 1'b0;
      end else if (mask_q[BIT_NOTCH]) begin
        out_d.event_kind = EV_NOTCH;
        out_d.position   = job_q.notch_pos;
        out_d.level      = job_q.notch_lvl;
        rem[BIT_NOTCH]   = 1'b0;
      end else begin
        out_d.event_kind = job_q.peak_kind;
        out_d.position   = job_q.peak_pos;
        out_d.level      = job_q.peak_lvl;
        rem[BIT_PEAK]    = 1'b0;
      end
      out_d.last_of_run = (rem == '0);
      out_vld_d         = 1'b1;
      mask_d            = rem;
    end
    q_pop_o = q_valid_i && (mask_d == '0);
    if (q_pop_o) begin
      job_d              = q_job_i;
      mask_d[BIT_VALLEY] = q_job_i.valley_vld;
      mask_d[BIT_NOTCH]  = q_job_i.notch_vld;
      mask_d[BIT_PEAK]   = q_job_i.peak_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      mask_q    <= mask_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `PFD_ASSERT_NEXT(a_job_has_events, clk_i, rst_ni, q_pop_o, mask_q != '0)

endmodule

### rtl/pulse_fiducial_detector_unit.sv
// ----------------------------------------------------------------------------
// pulse_fiducial_detector_unit
// Detects systolic and diastolic peaks, valleys and dicrotic notches in a
// normalized Q1.15 pulse stream.
// ----------------------------------------------------------------------------
// A sample is accepted in every cycle in which the two-entry job queue has
// room; the front end classifies it in that same cycle. Each sample yields
// zero to three events, sent one per cycle while the output is not stalled,
// from a registered output stage. A sample's events pass from the front end
// through the job queue, the back end's job register and the output
// register. Threshold writes take effect on the next accepted sample.

module pulse_fiducial_detector_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pfd_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [pfd_pkg::SAMPLE_BITS-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  input  pfd_pkg::in_t                     in_data_i,
  output logic                             in_stall_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output pfd_pkg::out_t                    out_data_o
);
  import pfd_pkg::*;

  logic q_push, q_full, q_pop, q_valid;
  job_t q_job_in, q_job_out;

  pfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_job_o    (q_job_in)
  );

  pfd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_job_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_job_out)
  );

  pfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_job_i     (q_job_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### sim/tb_pulse_fiducial_detector_unit.sv
// ----------------------------------------------------------------------------
// tb_pulse_fiducial_detector_unit
// Self-checking bench for the pulse fiducial detector. Samples are streamed
// in as records of synthetic pulse beats mixed with noise and extreme values,
// under several threshold settings and random stalls on both sides. A local
// predictor tracks the detector state and queues the expected peak, valley
// and notch events, which are compared in order with the output stream.
// ----------------------------------------------------------------------------
module tb_pulse_fiducial_detector_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import pfd_pkg::*;

  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLD_CYCLES    = 120;
  localparam int WATCHDOG_LIMIT = 1500;

  logic                    clk_i      = 1'b0;
  logic                    rst_ni     = 1'b0;
  logic                    cfg_we_i   = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i  = '0;
  logic [SAMPLE_BITS-1:0]  cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  in_t                     in_data_i  = '0;
  logic                    in_stall_o;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  out_t                    out_data_o;

  pulse_fiducial_detector_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // request source and expected events
  in_t  sample_q[$];
  out_t event_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned accepted_cnt  = 0;
  int unsigned hold_from     = 32'hFFFF_FFFF;
  int unsigned hold_left     = 0;
  bit          hold_done     = 1'b0;
  int unsigned queued_cnt    = 0;
  int          last_lvl      = 0;
  int unsigned mismatch_cnt  = 0;
  int unsigned quiet_cycles  = 0;

  // detector shadow
  sample_t sys_thr    = 16'sd21299;
  sample_t dia_thr    = 16'sd6554;
  sample_t hist[3]    = '{default: '0};
  index_t  sample_idx = '0;
  int      warm_cnt   = 0;
  bit      sys_seen   = 1'b0;
  sample_t min_lvl    = '0;
  index_t  min_pos    = '0;
  bit      dia_seen   = 1'b0;
  bit      notch_held = 1'b0;
  index_t  notch_pos  = '0;
  sample_t notch_lvl  = '0;

  task automatic report_mismatch(string msg);
    if (mismatch_cnt < 50) $display("[%0t] mismatch: %s", $time, msg);
    mismatch_cnt++;
  endtask

  task automatic classify_sample(in_t req);
    out_t    evs[$];
    sample_t xp;
    index_t  p;
    logic    peak;
    logic    sys_pk;
    logic    dia_pk;
    if (warm_cnt >= 3) begin
      xp     = hist[1];
      p      = sample_idx - index_t'(2);
      peak   = (xp > hist[2]) && (hist[0] <= xp) && (hist[0] > req.sample);
      sys_pk = peak && (xp > sys_thr);
      dia_pk = peak && !sys_pk && (xp > dia_thr) && (xp < sys_thr);
      if (sys_pk) begin
        if (sys_seen) evs.push_back(out_t'{EV_VALLEY, min_pos, min_lvl, 1'b0});
        if (notch_held) evs.push_back(out_t'{EV_NOTCH, notch_pos, notch_lvl, 1'b0});
        evs.push_back(out_t'{EV_SYSTOLIC, p, xp, 1'b0});
        sys_seen   = 1'b1;
        notch_held = 1'b0;
        dia_seen   = 1'b0;
        min_lvl    = xp;
        min_pos    = p;
      end else begin
        if (dia_pk) begin
          evs.push_back(out_t'{EV_DIASTOLIC, p, xp, 1'b0});
          // only the first diastolic peak after a systolic one fixes the notch
          if (sys_seen && !dia_seen) begin
            notch_held = 1'b1;
            notch_pos  = min_pos;
            notch_lvl  = min_lvl;
            dia_seen   = 1'b1;
          end
        end
        if (sys_seen && xp < min_lvl) begin
          min_lvl = xp;
          min_pos = p;
        end
      end
    end
    if (evs.size() > 0) evs[evs.size()-1].last_of_run = 1'b1;
    foreach (evs[i]) event_q.push_back(evs[i]);
    hist[2]    = hist[1];
    hist[1]    = hist[0];
    hist[0]    = req.sample;
    sample_idx = sample_idx + index_t'(1);
    if (warm_cnt < 3) warm_cnt++;
    if (req.end_of_record) begin
      hist       = '{default: '0};
      sample_idx = '0;
      warm_cnt   = 0;
      sys_seen   = 1'b0;
      min_lvl    = '0;
      min_pos    = '0;
      dia_seen   = 1'b0;
      notch_held = 1'b0;
      notch_pos  = '0;
      notch_lvl  = '0;
    end
  endtask

  always @(posedge clk_i) begin : driver
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        classify_sample(in_data_i);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (sample_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= sample_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // the result taken at one edge is checked at the next one, after every
  // expectation of that edge has been queued
  always @(posedge clk_i) begin : monitor
    out_t got;
    out_t want;
    logic got_fire;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      got_fire    = 1'b0;
    end else begin
      if (got_fire) begin
        if (event_q.size() == 0) begin
          report_mismatch($sformatf("unexpected event %s pos %0d level %0d",
                                    got.event_kind.name(), got.position, got.level));
        end else begin
          want = event_q.pop_front();
          if (got.event_kind != want.event_kind)
            report_mismatch($sformatf("event_kind %s, want %s",
                                      got.event_kind.name(), want.event_kind.name()));
          if (got.position != want.position)
            report_mismatch($sformatf("%s position %0d, want %0d",
                                      want.event_kind.name(), got.position, want.position));
          if (got.level != want.level)
            report_mismatch($sformatf("%s level %0d, want %0d",
                                      want.event_kind.name(), got.level, want.level));
          if (got.last_of_run != want.last_of_run)
            report_mismatch($sformatf("%s last_of_run %0b, want %0b",
                                      want.event_kind.name(), got.last_of_run,
                                      want.last_of_run));
        end
      end
      got_fire = out_valid_o && !out_stall_i;
      got      = out_data_o;
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left   <= hold_left - 1;
      end else if (!hold_done && accepted_cnt >= hold_from) begin
        hold_done   <= 1'b1;
        hold_left   <= HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: %0d cycles without a transfer, %0d events outstanding",
                 $time, quiet_cycles, event_q.size());
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_sample(int v, bit eor);
    in_t req;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    req.sample        = sample_t'(v);
    req.end_of_record = eor;
    sample_q.push_back(req);
    last_lvl = v;
    queued_cnt++;
  endtask

  task automatic push_ramp(int from, int to, int steps, int jit);
    int v;
    for (int k = 1; k <= steps; k++) begin
      v = from + (to - from) * k / steps;
      if (jit > 0) v += int'($urandom_range(2 * jit)) - jit;
      push_sample(v, 1'b0);
    end
  endtask

  // one synthetic beat: upstroke, systolic top, notch, diastolic bump, decay
  task automatic push_beat();
    int base;
    int top;
    int notch;
    int bump;
    int jit;
    base  = int'($urandom_range(20000)) - 20000;
    top   = 8000 + int'($urandom_range(24767));
    notch = base + (top - base) * int'($urandom_range(20, 70)) / 100;
    bump  = notch + (top - notch) * int'($urandom_range(10, 90)) / 100;
    jit   = ($urandom_range(3) == 0) ? 400 : 0;
    push_sample(base, 1'b0);
    push_ramp(base, top, $urandom_range(2, 6), jit);
    if ($urandom_range(1)) push_sample(last_lvl, 1'b0);
    push_ramp(top, notch, $urandom_range(1, 4), jit);
    push_ramp(notch, bump, $urandom_range(1, 4), jit);
    push_ramp(bump, base, $urandom_range(2, 8), jit);
  endtask

  task automatic queue_traffic(int unsigned count);
    int unsigned stop;
    int          picks[6];
    stop  = queued_cnt + count;
    picks = '{-32768, 32767, 0, -1, int'(sys_thr), int'(dia_thr)};
    while (queued_cnt < stop) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: push_beat();
        6: push_sample(int'(sample_t'($urandom)), 1'b0);
        7: push_sample(picks[$urandom_range(5)], 1'b0);
        8: push_sample(last_lvl + int'($urandom_range(2)) - 1, 1'b0);
        default: push_sample(int'(sample_t'($urandom)), 1'b1);
      endcase
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (sample_q.size() != 0 || in_valid_i || event_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_threshold(cfg_reg_e idx, sample_t val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_SYS_THR: sys_thr = val;
      CFG_DIA_THR: dia_thr = val;
      default: ;
    endcase
  endtask

  initial begin
    int          rec_peaks[13];
    int          rec_edges[7];
    rec_peaks = '{0, 30000, 10000, 5000, -32768, 15000, 12000, 11000, 20000,
                  32767, 32767, 0, 0};
    rec_edges = '{0, 10000, 5000, 0, 21299, 0, -1};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset thresholds: full beat with valley, notch and systolic on one
    // sample, then a diastolic peak with no systolic before it and a peak
    // sitting exactly on the systolic level
    @(negedge clk_i);
    foreach (rec_peaks[i]) push_sample(rec_peaks[i], i == 12);
    foreach (rec_edges[i]) push_sample(rec_edges[i], i == 6);
    wait_drained();

    write_threshold(CFG_SYS_THR, 16'sd15000);
    write_threshold(CFG_DIA_THR, 16'sd2000);
    @(negedge clk_i);
    send_idle_pct = 33;
    recv_idle_pct = 48;
    queue_traffic(140);
    wait_drained();

    // misordered extremes: every peak above the minimum is systolic
    write_threshold(CFG_SYS_THR, -16'sd32768);
    write_threshold(CFG_DIA_THR, 16'sd32767);
    @(negedge clk_i);
    send_idle_pct = 48;
    recv_idle_pct = 33;
    queue_traffic(70);
    wait_drained();

    // no systolic possible, nearly every peak diastolic
    write_threshold(CFG_SYS_THR, 16'sd32767);
    write_threshold(CFG_DIA_THR, -16'sd32768);
    @(negedge clk_i);
    queue_traffic(70);
    wait_drained();

    write_threshold(CFG_SYS_THR, sample_t'(12000 + $urandom_range(14000)));
    write_threshold(CFG_DIA_THR, sample_t'($urandom_range(10000)));
    @(negedge clk_i);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_from     = accepted_cnt + 25;
    queue_traffic(130);
    push_sample(0, 1'b1);
    wait_drained();

    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/pfd_pkg.sv
rtl/pfd_front.sv
rtl/pfd_fifo.sv
rtl/pfd_back.sv
rtl/pulse_fiducial_detector_unit.sv
sim/tb_pulse_fiducial_detector_unit.sv
